>>> sv/srm_pkg.sv
// Shared types and constants for the SPI register access master.
package srm_pkg;

  localparam int unsigned FRAME_BITS_DEF = 16;
  localparam int unsigned WORD_BITS      = 16;
  localparam int unsigned ADDR_BITS      = 4;
  localparam int unsigned DATA_BITS      = 11;
  localparam int unsigned DELAY_BITS     = 8;

  localparam logic [DATA_BITS-1:0]  READ_FILL      = 11'h7FF;
  localparam logic [DELAY_BITS-1:0] HALF_DELAY_RST = 8'd10;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_LEAD   = 7'b0000010,
    PH_HIGH   = 7'b0000100,
    PH_SAMPLE = 7'b0001000,
    PH_LOW    = 7'b0010000,
    PH_TAIL   = 7'b0100000,
    PH_GUARD  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic                 start_req;
    logic                 action;
    logic [ADDR_BITS-1:0] reg_addr;
    logic [DATA_BITS-1:0] write_data;
    logic                 miso;
  } srm_in_t;

  typedef struct packed {
    logic                 sck;
    logic                 mosi;
    logic                 cs_n;
    logic                 busy_res;
    logic                 done_res;
    logic [WORD_BITS-1:0] read_data;
  } srm_out_t;

endpackage

>>> sv/spi_register_access_master_top.sv
// Top level: input register, pin sequencer, result register and config register.
// A result is taken into the result register when the sequencer takes the held input,
// so each item passes through the input register and then the result register.
// Throughput: one transfer per cycle while the output is not stalled; each transfer is one tick of the sequencer.
// A stalled result holds the result register; the input register then stalls
// upstream only if it is itself full.
// Reset (rst, synchronous): sequencer idle, no result pending, delay = 10.
module spi_register_access_master_top
  import srm_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  srm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output srm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [DELAY_BITS-1:0] cfg_data
);

  logic                  in_q_valid;
  srm_in_t               in_q;
  logic                  fire;
  srm_out_t              res;
  logic [DELAY_BITS-1:0] half_delay;

  assign fire     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_delay <= HALF_DELAY_RST;
    end else if (cfg_we) begin
      half_delay <= cfg_data;
    end
  end

  srm_seq #(
    .FRAME_BITS(FRAME_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .item       (in_q),
    .half_delay (half_delay),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_data <= res;
    end
  end

endmodule

>>> sv/srm_seq.sv
// Pin sequencer: one tick of the SPI transaction per step.
module srm_seq
  import srm_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  srm_in_t               item,
  input  logic [DELAY_BITS-1:0] half_delay,
  output srm_out_t              res
);

  localparam int unsigned BCW = $clog2(FRAME_BITS + 1);

  phase_t                phase, phase_next;
  logic [BCW-1:0]        bit_count, bit_count_next;
  logic [DELAY_BITS-1:0] delay_count, delay_count_next;
  logic [1:0]            sample_count, sample_count_next;
  logic [2:0]            sample_bits, sample_bits_next;
  logic [FRAME_BITS-1:0] tx_shift, tx_shift_next;
  logic [FRAME_BITS-1:0] rx_shift, rx_shift_next;

  logic [DELAY_BITS-1:0] eff_delay;
  logic                  delay_hit;
  logic [2:0]            sb_tmp;
  logic                  maj;
  logic [BCW-1:0]        bc_inc;
  logic                  done;
  logic [WORD_BITS-1:0]  word;
  logic [FRAME_BITS-1:0] frame_load;
  logic [WORD_BITS-1:0]  rx_word;

  assign word = {item.action, item.reg_addr,
                 (item.action == ACT_READ) ? READ_FILL : item.write_data};

  generate
    if (FRAME_BITS == WORD_BITS) begin : g_frame_eq
      assign frame_load = word;
      assign rx_word    = rx_shift_next;
    end else if (FRAME_BITS > WORD_BITS) begin : g_frame_wide
      // word at the top, ones below
      assign frame_load = {word, {(FRAME_BITS - WORD_BITS){1'b1}}};
      assign rx_word    = rx_shift_next[WORD_BITS-1:0];
    end else begin : g_frame_narrow
      assign frame_load = word[WORD_BITS-1 -: FRAME_BITS];
      assign rx_word    = {{(WORD_BITS - FRAME_BITS){1'b0}}, rx_shift_next};
    end
  endgenerate

  // a zero delay setting is treated as a setting of one
  assign eff_delay = (half_delay == '0) ? DELAY_BITS'(1) : half_delay;
  assign delay_hit = ({1'b0, delay_count} + 9'd1) >= {1'b0, eff_delay};
  assign sb_tmp    = sample_bits | ({2'b00, item.miso} << sample_count);
  assign maj       = (sb_tmp[0] & sb_tmp[1]) | (sb_tmp[0] & sb_tmp[2]) |
                     (sb_tmp[1] & sb_tmp[2]);
  assign bc_inc    = bit_count + BCW'(1);

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    delay_count_next  = delay_count;
    sample_count_next = sample_count;
    sample_bits_next  = sample_bits;
    tx_shift_next     = tx_shift;
    rx_shift_next     = rx_shift;
    done              = 1'b0;
    unique case (phase)
      PH_LEAD: begin
        if (delay_hit) begin
          phase_next       = PH_HIGH;
          delay_count_next = '0;
        end else begin
          delay_count_next = delay_count + DELAY_BITS'(1);
        end
      end
      PH_HIGH: begin
        if (delay_hit) begin
          phase_next        = PH_SAMPLE;
          delay_count_next  = '0;
          sample_bits_next  = {2'b00, item.miso};
          sample_count_next = 2'd1;
        end else begin
          delay_count_next = delay_count + DELAY_BITS'(1);
        end
      end
      PH_SAMPLE: begin
        sample_bits_next  = sb_tmp;
        sample_count_next = sample_count + 2'd1;
        if (sample_count >= 2'd2) begin
          rx_shift_next     = {rx_shift[FRAME_BITS-2:0], maj};
          sample_count_next = '0;
          phase_next        = PH_LOW;
          delay_count_next  = '0;
        end
      end
      PH_LOW: begin
        if (delay_hit) begin
          tx_shift_next    = {tx_shift[FRAME_BITS-2:0], 1'b1};
          delay_count_next = '0;
          if (bc_inc >= BCW'(FRAME_BITS)) begin
            bit_count_next = '0;
            phase_next     = PH_TAIL;
          end else begin
            bit_count_next = bc_inc;
            phase_next     = PH_HIGH;
          end
        end else begin
          delay_count_next = delay_count + DELAY_BITS'(1);
        end
      end
      PH_TAIL: begin
        if (delay_hit) begin
          phase_next       = PH_GUARD;
          delay_count_next = '0;
        end else begin
          delay_count_next = delay_count + DELAY_BITS'(1);
        end
      end
      PH_GUARD: begin
        if (delay_hit) begin
          phase_next       = PH_IDLE;
          delay_count_next = '0;
          done             = 1'b1;
        end else begin
          delay_count_next = delay_count + DELAY_BITS'(1);
        end
      end
      default: begin
        // idle, and any stray code
        phase_next = PH_IDLE;
        if (item.start_req) begin
          tx_shift_next     = frame_load;
          rx_shift_next     = '0;
          bit_count_next    = '0;
          sample_count_next = '0;
          sample_bits_next  = '0;
          phase_next        = PH_LEAD;
          delay_count_next  = '0;
        end
      end
    endcase
  end

  always_comb begin
    res.sck       = (phase_next == PH_HIGH);
    res.mosi      = tx_shift_next[FRAME_BITS-1];
    res.cs_n      = (phase_next == PH_IDLE) || (phase_next == PH_GUARD);
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.read_data = done ? rx_word : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      delay_count  <= '0;
      sample_count <= '0;
      sample_bits  <= '0;
      tx_shift     <= '1;
      rx_shift     <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      delay_count  <= delay_count_next;
      sample_count <= sample_count_next;
      sample_bits  <= sample_bits_next;
      tx_shift     <= tx_shift_next;
      rx_shift     <= rx_shift_next;
    end
  end

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count < BCW'(FRAME_BITS))
    else $error("bit counter past frame length");

  a_sample_to_low: assert property (@(posedge clk) disable iff (rst)
    (step && (phase == PH_SAMPLE) && (sample_count == 2'd2)) |=> (phase == PH_LOW))
    else $error("third sample did not move on to low phase");

  a_done_from_guard: assert property (@(posedge clk) disable iff (rst)
    (step && res.done_res) |-> (phase == PH_GUARD) && !res.busy_res && res.cs_n)
    else $error("done outside the end of guard phase");

  a_idle_mosi_high: assert property (@(posedge clk) disable iff (rst)
    (step && (phase == PH_GUARD) && delay_hit) |=> (phase == PH_IDLE) && tx_shift[FRAME_BITS-1])
    else $error("mosi not high on return to idle");

endmodule
